// ----- sv/b64u_pkg.sv -----
// Shared types, constants and the character map of the base64url stream encoder.
package b64u_pkg;

  // Reset codes of the two configurable alphabet characters
  localparam logic [7:0] RST_CHAR_62 = 8'd45;
  localparam logic [7:0] RST_CHAR_63 = 8'd95;
  localparam logic [7:0] PAD_CHAR    = 8'd61;

  // Register indexes on the configuration port
  localparam logic REG_CHAR_62 = 1'b0;
  localparam logic REG_CHAR_63 = 1'b1;

  // Job queue between the front and back ends
  localparam int JOBQ_DEPTH = 2;
  localparam int JOBQ_AW    = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
  localparam int JOBQ_CW    = $clog2(JOBQ_DEPTH + 1);

  // Position inside a group of three bytes
  typedef enum logic [1:0] {
    PH_0 = 2'd0,
    PH_1 = 2'd1,
    PH_2 = 2'd2
  } phase_t;

  // One output symbol: a six-bit value or a pad character
  typedef struct packed {
    logic       pad;
    logic [5:0] val;
  } sym_t;

  // Everything one input byte causes: up to four symbols, sym[0] first
  typedef struct packed {
    logic           fin;
    logic [1:0]     last;
    sym_t [3:0]     sym;
  } job_t;

  // Front end to job queue
  typedef struct packed {
    logic push;
    job_t job;
  } jobq_wr_t;

  // Job queue head to back end
  typedef struct packed {
    logic empty;
    job_t job;
  } jobq_rd_t;

  // Map a six-bit value to its URL-safe alphabet code
  function automatic logic [7:0] sextet_char(input logic [5:0] v,
                                             input logic [7:0] c62,
                                             input logic [7:0] c63);
    logic [7:0] v8;
    v8 = {2'b00, v};
    if (v < 6'd26) begin
      return v8 + 8'd65;
    end else if (v < 6'd52) begin
      return v8 + 8'd71;
    end else if (v < 6'd62) begin
      return v8 - 8'd4;
    end else if (v == 6'd62) begin
      return c62;
    end else begin
      return c63;
    end
  endfunction

endpackage

// ----- sv/b64u_front.sv -----
// Front end: accepts bytes, tracks the group phase and splits each byte into symbols.
module b64u_front import b64u_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic       q_full,
  input  logic [7:0] in_data_byte,
  input  logic       in_final_byte,
  output jobq_wr_t   q_wr
);

  phase_t     phase_r, phase_nxt;
  logic [3:0] carry_r, carry_nxt;
  logic       accept;
  job_t       job;

  assign accept = push && !q_full;

  // Classify the byte against the current phase
  always_comb begin
    job         = '0;
    job.fin     = in_final_byte;
    phase_nxt   = PH_0;
    carry_nxt   = 4'd0;
    case (phase_r)
      PH_1: begin
        job.sym[0].val = {carry_r[1:0], in_data_byte[7:4]};
        job.sym[1].val = {in_data_byte[3:0], 2'b00};
        job.sym[2].pad = 1'b1;
        job.last       = in_final_byte ? 2'd2 : 2'd0;
        phase_nxt      = PH_2;
        carry_nxt      = in_data_byte[3:0];
      end
      PH_2: begin
        job.sym[0].val = {carry_r, in_data_byte[7:6]};
        job.sym[1].val = in_data_byte[5:0];
        job.last       = 2'd1;
        phase_nxt      = PH_0;
        carry_nxt      = 4'd0;
      end
      default: begin
        job.sym[0].val = in_data_byte[7:2];
        job.sym[1].val = {in_data_byte[1:0], 4'b0000};
        job.sym[2].pad = 1'b1;
        job.sym[3].pad = 1'b1;
        job.last       = in_final_byte ? 2'd3 : 2'd0;
        phase_nxt      = PH_1;
        carry_nxt      = {2'b00, in_data_byte[1:0]};
      end
    endcase
    // Drop the group state at the end of a message
    if (in_final_byte) begin
      phase_nxt = PH_0;
      carry_nxt = 4'd0;
    end
  end

  assign q_wr.push = accept;
  assign q_wr.job  = job;

  // Advance the group state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_0;
      carry_r <= 4'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
    end
  end

endmodule

// ----- sv/b64u_jobq.sv -----
// Small job queue that parts the front end from the back end.
module b64u_jobq import b64u_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  jobq_wr_t q_wr,
  input  logic     q_pop,
  output logic     q_full,
  output jobq_rd_t q_rd
);

  job_t                 mem_r [JOBQ_DEPTH];
  logic [JOBQ_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [JOBQ_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [JOBQ_CW-1:0]   cnt_r, cnt_nxt;
  logic                 do_wr, do_rd;

  assign q_full   = (cnt_r == JOBQ_CW'(JOBQ_DEPTH));
  assign q_rd.empty = (cnt_r == '0);
  assign q_rd.job   = mem_r[rd_ptr_r];

  assign do_wr = q_wr.push && !q_full;
  assign do_rd = q_pop && !q_rd.empty;

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == JOBQ_AW'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == JOBQ_AW'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the job payload
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= q_wr.job;
    end
  end

endmodule

// ----- sv/b64u_back.sv -----
// Back end: walks job symbols and registers one char per cycle unless stalled.
module b64u_back import b64u_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  jobq_rd_t   q_rd,
  output logic       q_pop,
  input  logic [7:0] char_62,
  input  logic [7:0] char_63,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic       out_end_of_text
);

  logic [1:0] idx_r, idx_nxt;
  logic       vld_r, vld_nxt;
  logic [7:0] char_r, char_nxt;
  logic       eot_r, eot_nxt;
  logic       load;
  logic       at_last;
  sym_t       sym;

  assign sym     = q_rd.job.sym[idx_r];
  assign at_last = (idx_r == q_rd.job.last);
  assign load    = !q_rd.empty && (!vld_r || pop);
  assign q_pop   = load && at_last;

  // Pick the next character and step through the job
  always_comb begin
    idx_nxt  = idx_r;
    vld_nxt  = vld_r && !pop;
    char_nxt = char_r;
    eot_nxt  = eot_r;
    if (load) begin
      vld_nxt  = 1'b1;
      char_nxt = sym.pad ? PAD_CHAR : sextet_char(sym.val, char_62, char_63);
      eot_nxt  = q_rd.job.fin && at_last;
      idx_nxt  = at_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  // Hold the result payload until taken
  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    eot_r  <= eot_nxt;
  end

  assign empty           = !vld_r;
  assign out_char        = char_r;
  assign out_end_of_text = eot_r;

endmodule

// ----- sv/base64url_stream_encoder_core.sv -----
// Top level of the base64url stream encoder: config registers, front, job queue, back.
// Bytes enter one per item and leave as URL-safe base64 characters, one per item, the
// last character of a message marked by out_end_of_text. A byte is taken in any cycle
// the two-entry job queue has room; the back end sends one character per cycle while
// a job waits and the output is taken, so a group of three bytes gives four characters
// and a final byte up to four. With the back end idle, the first character of a byte
// passes the job queue and then the single character output register. The codes for
// sextets 62 and 63 sit at byte addresses 0 and 4 (reset '-' and '_'); the user
// writes them only while no message is in flight; the block does not enforce this.
module base64url_stream_encoder_core import b64u_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_final_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_char,
  output logic        out_end_of_text,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] char_62_r, char_63_r;
  logic       cfg_wr;
  logic       cfg_sel;
  jobq_wr_t   q_wr;
  jobq_rd_t   q_rd;
  logic       q_pop;

  // Decode the register from the word address
  assign cfg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = {24'd0, (cfg_sel == REG_CHAR_63) ? char_63_r : char_62_r};

  // Update alphabet registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_62_r <= RST_CHAR_62;
      char_63_r <= RST_CHAR_63;
    end else if (cfg_wr) begin
      if (cfg_sel == REG_CHAR_62) begin
        char_62_r <= pwdata[7:0];
      end else begin
        char_63_r <= pwdata[7:0];
      end
    end
  end

  b64u_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .q_full        (full),
    .in_data_byte  (in_data_byte),
    .in_final_byte (in_final_byte),
    .q_wr          (q_wr)
  );

  b64u_jobq u_jobq (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_pop  (q_pop),
    .q_full (full),
    .q_rd   (q_rd)
  );

  b64u_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_rd            (q_rd),
    .q_pop           (q_pop),
    .char_62         (char_62_r),
    .char_63         (char_63_r),
    .empty           (empty),
    .pop             (pop),
    .out_char        (out_char),
    .out_end_of_text (out_end_of_text)
  );

endmodule

// ----- sv/b64u_checker.sv -----
// Port-level checks of the base64url stream encoder, bound to the top level.
module b64u_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        push,
  input logic        full,
  input logic [7:0]  in_data_byte,
  input logic        in_final_byte,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  out_char,
  input logic        out_end_of_text,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // A waiting item holds until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_char) && $stable(out_end_of_text)))
    else $error("result item changed while stalled");

  // Reset leaves the output empty and the job queue not full
  a_rst: assert property (@(posedge clk)
    ($past(rst_n) == 1'b0) |-> (empty && !full))
    else $error("queues not drained after reset");

  // A written register reads back at the same address
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && pready) |=>
      (($past(paddr[2]) != paddr[2]) || (prdata[7:0] == $past(pwdata[7:0]))))
    else $error("register readback mismatch");

  // Upper read data stays clear
  a_rdz: assert property (@(posedge clk) disable iff (!rst_n)
    psel |-> (prdata[31:8] == 24'd0))
    else $error("nonzero upper read data");

endmodule

bind base64url_stream_encoder_core b64u_checker u_b64u_checker (.*);

// ----- tb/sv/base64url_stream_encoder_core_tb.sv -----
// Self-checking testbench for the base64url stream encoder core.
module base64url_stream_encoder_core_tb import b64u_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 90;

  // Expected characters and the encoder state that produces them
  class b64_scoreboard;
    typedef struct packed {
      logic [7:0] ch;
      logic       eot;
    } enc_char_t;

    logic [7:0] code62;
    logic [7:0] code63;
    phase_t     phase;
    logic [3:0] carry;
    enc_char_t  char_q[$];
    int         mismatches;
    int         chars_checked;
    int         bytes_seen;
    int         messages;
    int         reg_writes;

    function new();
      code62 = RST_CHAR_62;
      code63 = RST_CHAR_63;
      phase  = PH_0;
      carry  = 4'd0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t ERROR: %s", $realtime, msg);
    endfunction

    function int pending();
      return char_q.size();
    endfunction

    function void set_code(logic idx, logic [7:0] code);
      reg_writes++;
      if (idx == REG_CHAR_62) code62 = code;
      else code63 = code;
    endfunction

    // Map a six-bit value onto the URL-safe alphabet
    function logic [7:0] sextet_code(logic [5:0] v);
      if (v < 6'd26) return 8'd65 + 8'(v);
      if (v < 6'd52) return 8'd71 + 8'(v);
      if (v < 6'd62) return 8'(v) - 8'd4;
      if (v == 6'd62) return code62;
      return code63;
    endfunction

    function void push_char(logic [7:0] ch);
      enc_char_t c;
      c.ch  = ch;
      c.eot = 1'b0;
      char_q.push_back(c);
    endfunction

    // Advance the group phase by one byte and queue the characters it yields
    function void note_byte(logic [7:0] b, logic last);
      bytes_seen++;
      case (phase)
        PH_1: begin
          push_char(sextet_code({carry[1:0], b[7:4]}));
          carry = b[3:0];
          phase = PH_2;
          if (last) begin
            push_char(sextet_code({b[3:0], 2'b00}));
            push_char(PAD_CHAR);
          end
        end
        PH_2: begin
          push_char(sextet_code({carry, b[7:6]}));
          push_char(sextet_code(b[5:0]));
          carry = 4'd0;
          phase = PH_0;
        end
        default: begin
          push_char(sextet_code(b[7:2]));
          carry = {2'b00, b[1:0]};
          phase = PH_1;
          if (last) begin
            push_char(sextet_code({b[1:0], 4'b0000}));
            push_char(PAD_CHAR);
            push_char(PAD_CHAR);
          end
        end
      endcase
      // Mark the end of text and restart the group
      if (last) begin
        char_q[char_q.size() - 1].eot = 1'b1;
        phase = PH_0;
        carry = 4'd0;
        messages++;
      end
    endfunction

    function void check_char(logic [7:0] ch, logic eot);
      enc_char_t want;
      chars_checked++;
      if (char_q.size() == 0) begin
        flag($sformatf("unexpected char 0x%02h eot %b", ch, eot));
        return;
      end
      want = char_q.pop_front();
      if (ch !== want.ch || eot !== want.eot)
        flag($sformatf("char %0d: expected 0x%02h eot %b, got 0x%02h eot %b",
                       chars_checked, want.ch, want.eot, ch, eot));
    endfunction

    function void check_reg(logic idx, logic [31:0] rdata);
      logic [31:0] want;
      want = {24'd0, (idx == REG_CHAR_62) ? code62 : code63};
      if (rdata !== want)
        flag($sformatf("register %0d read: expected 0x%08h, got 0x%08h", idx, want, rdata));
    endfunction

    function void check_drained();
      if (char_q.size() != 0)
        flag($sformatf("%0d expected chars never arrived", char_q.size()));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [7:0]  in_data_byte;
  logic        in_final_byte;
  logic        empty;
  logic        pop;
  logic [7:0]  out_char;
  logic        out_end_of_text;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  b64_scoreboard sb = new();

  int   tx_idle_pct;
  int   rx_idle_pct;
  int   stuck_cycles;
  int   hold_left;
  logic hold_req;
  logic progress;

  base64url_stream_encoder_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_data_byte    (in_data_byte),
    .in_final_byte   (in_final_byte),
    .empty           (empty),
    .pop             (pop),
    .out_char        (out_char),
    .out_end_of_text (out_end_of_text),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watch every handshake at the rising edge and track progress
  always @(posedge clk) begin
    if (rst_n) begin
      progress = 1'b0;
      if (push && !full) begin
        sb.note_byte(in_data_byte, in_final_byte);
        progress = 1'b1;
      end
      if (pop && !empty) begin
        sb.check_char(out_char, out_end_of_text);
        progress = 1'b1;
      end
      if (psel && penable && pready) begin
        if (pwrite) sb.set_code(paddr[2], pwdata[7:0]);
        progress = 1'b1;
      end
      stuck_cycles = progress ? 0 : stuck_cycles + 1;
    end
  end

  // Give up when nothing moves for too long
  initial begin
    stuck_cycles = 0;
    wait (stuck_cycles >= STALL_LIMIT);
    $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // Drive pop: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      pop = 1'b0;
    end else begin
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        pop = 1'b0;
        hold_left--;
      end else begin
        pop = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offer one item and hold it until the block takes it
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push          = 1'b1;
    in_data_byte  = b;
    in_final_byte = last;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  // Send a message of random bytes, biased toward edge patterns
  task automatic send_message(input int len);
    logic [7:0] b;
    logic [7:0] edge_bytes [6];
    edge_bytes = '{8'h00, 8'hFF, 8'hF8, 8'hFC, 8'h03, 8'h80};
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(4) == 0) b = edge_bytes[$urandom_range(5)];
      else b = 8'($urandom());
      send_byte(b, i == len - 1);
    end
  endtask

  // Stop offering items until every expected char has come out
  task automatic drain_output();
    push = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic read_char_reg(input logic idx);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.check_reg(idx, prdata);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Write one alphabet register, junk in the upper bits, then read it back
  task automatic write_char_reg(input logic idx, input logic [7:0] code);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {24'($urandom()), code};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    read_char_reg(idx);
  endtask

  task automatic set_alphabet(input logic [7:0] c62, input logic [7:0] c63);
    drain_output();
    write_char_reg(REG_CHAR_62, c62);
    write_char_reg(REG_CHAR_63, c63);
  endtask

  // Random messages, mostly short, now and then a long one
  task automatic random_messages(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
      send_message(len);
      sent += len;
    end
  endtask

  // Bytes whose sextets are all 62, then all 63 with a lone byte after the group
  task automatic send_top_codes();
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  initial begin
    rst_n         = 1'b0;
    push          = 1'b0;
    in_data_byte  = 8'd0;
    in_final_byte = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = 3'd0;
    pwdata        = 32'd0;
    hold_req      = 1'b0;
    hold_left     = 0;
    tx_idle_pct   = 0;
    rx_idle_pct   = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Check reset values of the alphabet registers
    read_char_reg(REG_CHAR_62);
    read_char_reg(REG_CHAR_63);

    // Directed: end of text at each phase, both top codes, alphabet boundaries
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_top_codes();
    send_byte(8'h65, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hF4, 1'b0);
    send_byte(8'hF4, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'h7E, 1'b1);

    // Extreme register codes
    set_alphabet(8'h00, 8'hFF);
    send_top_codes();
    set_alphabet(8'hFF, 8'h00);
    send_top_codes();

    // Receiver idles more than sender, with a full pause midway
    set_alphabet(8'($urandom()), 8'($urandom()));
    tx_idle_pct = 36;
    rx_idle_pct = 53;
    random_messages(10);
    drain_output();
    random_messages(10);

    // Sender idles more than receiver
    set_alphabet(8'd43, 8'd47);
    tx_idle_pct = 53;
    rx_idle_pct = 36;
    random_messages(24);

    // No idling; hold off the receiver so the input backs up
    set_alphabet(8'($urandom()), 8'($urandom()));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = 1'b1;
    send_message(14);
    random_messages(20);

    // Let the tail drain, then look for stray chars
    drain_output();
    repeat (8) @(negedge clk);
    sb.check_drained();

    $display("Encoded %0d bytes in %0d messages, %0d chars checked, %0d register writes.",
             sb.bytes_seen, sb.messages, sb.chars_checked, sb.reg_writes);
    $display("Ran three stall mixes, a long output hold-off and a full drain pause.");
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
